### src/ptil_pkg.sv
// Shared constants, request codes and state type for the prefix tree block.
package ptil_pkg;

    // Default sizes of the tree.
    localparam int NODE_COUNT_DEF = 4096;
    localparam int ALPHABET_DEF   = 26;
    localparam int COUNT_BITS_DEF = 16;

    // Fixed field widths on the channels.
    localparam int REQ_W       = 2;
    localparam int SYM_W       = 5;
    localparam int NODE_OUT_W  = 12;
    localparam int COUNT_OUT_W = 16;

    // Width used when comparing a symbol against the alphabet size.
    localparam int SYM_CMP_W = 9;

    // Request codes; the fourth code behaves as a prefix query.
    localparam logic [REQ_W-1:0] REQ_INSERT     = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PREFIX     = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PREFIX_ALT = 2'd3;

    // Status codes.
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_POOL_FULL = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } ptil_state_t;

endpackage

### src/ptil_in_if.sv
// Input and result channel interfaces of the prefix tree block.
interface ptil_in_if import ptil_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output req_type, output symbol, output last, input ready);
    modport sink (input valid, input req_type, input symbol, input last, output ready);
endinterface

interface ptil_out_if import ptil_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [NODE_OUT_W-1:0]  end_node;
    logic [COUNT_OUT_W-1:0] word_count;
    logic [COUNT_OUT_W-1:0] prefix_count;
    logic                   status;

    modport source (
        output valid, output hit, output end_node, output word_count,
        output prefix_count, output status, input ready
    );
    modport sink (
        input valid, input hit, input end_node, input word_count,
        input prefix_count, input status, output ready
    );
endinterface

### src/ptil_row_mem.sv
// Node row memory: one write port and one registered read port.
module ptil_row_mem import ptil_pkg::*; #(
    parameter int DEPTH     = NODE_COUNT_DEF,
    parameter int ADDR_BITS = $clog2(NODE_COUNT_DEF),
    parameter int ROW_BITS  = 64
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [ROW_BITS-1:0]  wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [ROW_BITS-1:0]  rd_data
);

    logic [ROW_BITS-1:0] mem [DEPTH];

    // Write first in program order, but the read returns the old row on a collision.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### src/prefix_tree_insert_lookup_top.sv
// Top level of the prefix tree: walk sequencer, row update logic and result register.
//
//   channel | dir | fields                                            | accepted when
//   req     | in  | req_type, symbol, last                            | valid && ready
//   rsp     | out | hit, end_node, word_count, prefix_count, status   | valid && ready
//
// A letter that is not last needs one row read, then link select and write back.
// A last letter adds a final state plus any wait for the result register to drain;
// that state takes the final node's row for its counts. The single-port row read
// sets this order. After reset a clearing sweep writes every node row to zero before the
// first item is taken. A stalled result holds only the last letter's final state.
module prefix_tree_insert_lookup_top import ptil_pkg::*; #(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int ALPHABET   = ALPHABET_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ptil_in_if.sink     req,
    ptil_out_if.source  rsp
);

    localparam int NODE_BITS = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int USED_BITS = $clog2(NODE_COUNT + 1);
    localparam int SYM_BITS  = $clog2(ALPHABET);
    localparam int LINK_BITS = ALPHABET * NODE_BITS;
    localparam int PASS_LO   = LINK_BITS;
    localparam int END_LO    = LINK_BITS + COUNT_BITS;
    localparam int ROW_BITS  = LINK_BITS + 2 * COUNT_BITS;

    ptil_state_t state_reg, state_next;

    logic [NODE_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [NODE_BITS-1:0] cursor_reg, cursor_next;
    logic                 missed_reg, missed_next;
    logic                 full_reg, full_next;
    logic [USED_BITS-1:0] nodes_used_reg, nodes_used_next;

    logic [REQ_W-1:0]     req_type_reg;
    logic [SYM_BITS-1:0]  sym_reg;
    logic                 last_reg;
    logic [SYM_BITS-1:0]  sym_sat;

    logic                   out_valid_reg, out_valid_next;
    logic                   hit_reg, hit_next;
    logic [NODE_OUT_W-1:0]  end_node_reg, end_node_next;
    logic [COUNT_OUT_W-1:0] word_count_reg, word_count_next;
    logic [COUNT_OUT_W-1:0] prefix_count_reg, prefix_count_next;
    logic                   status_reg, status_next;

    logic                 wr_en;
    logic [NODE_BITS-1:0] wr_addr;
    logic [ROW_BITS-1:0]  wr_row;
    logic [NODE_BITS-1:0] rd_addr;
    logic [ROW_BITS-1:0]  rd_row;

    logic                  accept;
    logic                  fin_go;
    logic                  active;
    logic                  is_insert;
    logic [NODE_BITS-1:0]  link;
    logic                  link_empty;
    logic                  can_alloc;
    logic [COUNT_BITS-1:0] pass_cnt;
    logic [COUNT_BITS-1:0] end_cnt;
    logic [COUNT_BITS-1:0] pass_bump;
    logic [COUNT_BITS-1:0] end_bump;
    logic [COUNT_BITS-1:0] pass_res;
    logic [COUNT_BITS-1:0] end_res;
    logic [31:0]           node_wide;
    logic [31:0]           pass_wide;
    logic [31:0]           end_wide;

    // Node row storage.
    ptil_row_mem #(
        .DEPTH     (NODE_COUNT),
        .ADDR_BITS (NODE_BITS),
        .ROW_BITS  (ROW_BITS)
    ) u_row_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_row),
        .rd_addr (rd_addr),
        .rd_data (rd_row)
    );

    // Handshake and common decode.
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign fin_go    = !out_valid_reg || rsp.ready;
    assign active    = !missed_reg && !full_reg;
    assign is_insert = (req_type_reg == REQ_INSERT);

    // Symbols past the alphabet fall onto its last letter.
    assign sym_sat = (SYM_CMP_W'(req.symbol) >= SYM_CMP_W'(ALPHABET))
                   ? SYM_BITS'(ALPHABET - 1) : SYM_BITS'(req.symbol);

    // Fields of the row just read.
    assign link       = rd_row[sym_reg * NODE_BITS +: NODE_BITS];
    assign link_empty = (link == '0);
    assign can_alloc  = (nodes_used_reg < USED_BITS'(NODE_COUNT));
    assign pass_cnt   = rd_row[PASS_LO +: COUNT_BITS];
    assign end_cnt    = rd_row[END_LO +: COUNT_BITS];
    assign pass_bump  = (pass_cnt == '1) ? pass_cnt : pass_cnt + COUNT_BITS'(1);
    assign end_bump   = (end_cnt == '1) ? end_cnt : end_cnt + COUNT_BITS'(1);

    // Counts reported on the final node, raised first for an insert.
    assign pass_res  = is_insert ? pass_bump : pass_cnt;
    assign end_res   = is_insert ? end_bump : end_cnt;
    assign node_wide = 32'(cursor_reg);
    assign pass_wide = 32'(pass_res);
    assign end_wide  = 32'(end_res);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == NODE_BITS'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Walk datapath, memory ports and result loading.
    always_comb
    begin
        clr_cnt_next      = clr_cnt_reg;
        cursor_next       = cursor_reg;
        missed_next       = missed_reg;
        full_next         = full_reg;
        nodes_used_next   = nodes_used_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        hit_next          = hit_reg;
        end_node_next     = end_node_reg;
        word_count_next   = word_count_reg;
        prefix_count_next = prefix_count_reg;
        status_next       = status_reg;
        wr_en             = 1'b0;
        wr_addr           = cursor_reg;
        wr_row            = rd_row;
        rd_addr           = cursor_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep every row to empty links and zero counts.
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_row       = '0;
                clr_cnt_next = clr_cnt_reg + NODE_BITS'(1);
            end
            ST_EXEC:
            begin
                if (active)
                begin
                    if (is_insert)
                    begin
                        // Raise the pass count and allocate the child when missing.
                        wr_en                      = 1'b1;
                        wr_row[PASS_LO +: COUNT_BITS] = pass_bump;
                        if (link_empty)
                        begin
                            if (can_alloc)
                            begin
                                wr_row[sym_reg * NODE_BITS +: NODE_BITS] =
                                    NODE_BITS'(nodes_used_reg);
                                nodes_used_next = nodes_used_reg + USED_BITS'(1);
                                cursor_next     = NODE_BITS'(nodes_used_reg);
                            end
                            else
                            begin
                                full_next = 1'b1;
                            end
                        end
                        else
                        begin
                            cursor_next = link;
                        end
                    end
                    else if (link_empty)
                    begin
                        missed_next = 1'b1;
                    end
                    else
                    begin
                        cursor_next = link;
                    end
                end
                // Fetch the row of the node the letter lands on.
                rd_addr = cursor_next;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next    = 1'b1;
                    hit_next          = 1'b0;
                    end_node_next     = '0;
                    word_count_next   = '0;
                    prefix_count_next = '0;
                    status_next       = STATUS_OK;
                    if (full_reg)
                    begin
                        status_next = STATUS_POOL_FULL;
                    end
                    else if (!missed_reg)
                    begin
                        end_node_next     = node_wide[NODE_OUT_W-1:0];
                        word_count_next   = end_wide[COUNT_OUT_W-1:0];
                        prefix_count_next = pass_wide[COUNT_OUT_W-1:0];
                        case (req_type_reg)
                            REQ_INSERT:
                            begin
                                hit_next = 1'b1;
                                wr_en    = 1'b1;
                                wr_row[PASS_LO +: COUNT_BITS] = pass_bump;
                                wr_row[END_LO +: COUNT_BITS]  = end_bump;
                            end
                            REQ_SEARCH:
                            begin
                                hit_next = (end_cnt != '0);
                            end
                            default:
                            begin
                                hit_next = (pass_cnt != '0);
                            end
                        endcase
                    end
                    // The next word starts again from the root.
                    cursor_next = '0;
                    missed_next = 1'b0;
                    full_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            cursor_reg     <= '0;
            missed_reg     <= 1'b0;
            full_reg       <= 1'b0;
            nodes_used_reg <= USED_BITS'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            cursor_reg     <= cursor_next;
            missed_reg     <= missed_next;
            full_reg       <= full_next;
            nodes_used_reg <= nodes_used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg <= req.req_type;
            sym_reg      <= sym_sat;
            last_reg     <= req.last;
        end
        hit_reg          <= hit_next;
        end_node_reg     <= end_node_next;
        word_count_reg   <= word_count_next;
        prefix_count_reg <= prefix_count_next;
        status_reg       <= status_next;
    end

    // Result channel.
    assign rsp.valid        = out_valid_reg;
    assign rsp.hit          = hit_reg;
    assign rsp.end_node     = end_node_reg;
    assign rsp.word_count   = word_count_reg;
    assign rsp.prefix_count = prefix_count_reg;
    assign rsp.status       = status_reg;

endmodule
